// ----- rtl/circular_deque_assert.svh -----
// Assertion macros for the deque RTL, used by the top level.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Checked on every rising edge outside of reset.
`define CD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/cd_pkg.sv -----
// Shared constants, codes and types of the circular deque.
package cd_pkg;

  localparam int DATA_W    = 32;
  localparam int OP_W      = 3;
  localparam int STATUS_W  = 2;
  localparam int DEPTH_DEF = 4;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_REAR  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_REAR   = 3'd3;
  localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd2;

  // Commands broadcast to every cell of the row; at most one is set.
  typedef struct packed {
    logic push_front;
    logic push_rear;
    logic pop_front;
    logic pop_rear;
  } cd_ctrl_t;

endpackage

// ----- rtl/cd_if.sv -----
// Valid/ready channel interfaces for request and result words.
interface cd_in_if;
  logic                                  valid;
  logic                                  ready;
  logic        [cd_pkg::OP_W-1:0]        op;
  logic signed [cd_pkg::DATA_W-1:0]      push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

interface cd_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cd_pkg::DATA_W-1:0]      read_value;
  logic        [cd_pkg::STATUS_W-1:0]    status;
  logic                                  is_empty;
  logic                                  is_full;

  modport source (output valid, output read_value, output status, output is_empty,
                  output is_full, input ready);
  modport sink   (input valid, input read_value, input status, input is_empty,
                  input is_full, output ready);
endinterface

// ----- rtl/circular_deque.sv -----
// Top level of the circular deque: a row of shifting cells and a result register.
//
//   channel  | dir | handshake         | payload
//   ---------+-----+-------------------+----------------------------------------
//   in_w     | in  | valid/ready       | op, push_value
//   out_w    | out | valid/ready       | read_value, status, is_empty, is_full
//
// One request word is taken per cycle; its result appears in the next cycle.
// The result register is the only stage, so the rate is set by how fast the
// sink drains it: a new request is taken whenever that register is empty or
// being read in the same cycle. Reset clears the occupancy bits of all cells and
// the result register's valid bit at once; no clearing pass follows. While the sink
// stalls with a result pending, in_w.ready stays low and the cells hold.
module circular_deque #(
  parameter int DEPTH = cd_pkg::DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  cd_in_if.sink   in_w,
  cd_out_if.source out_w
);
  import cd_pkg::*;

  // The deque is kept compacted: entry k from the front lives in cell k, so
  // the occupancy bits always form a run of ones starting at cell 0.
  logic signed [DATA_W-1:0] data_w [DEPTH];
  logic signed [DATA_W-1:0] tap_w  [DEPTH];
  logic        [DEPTH-1:0]  valid_w;

  cd_ctrl_t ctrl, cell_ctrl;
  logic     fire;
  logic     empty, full;
  logic signed [DATA_W-1:0] rear_data;

  logic                     out_valid_r;
  logic signed [DATA_W-1:0] rd_r, rd_nxt;
  logic [STATUS_W-1:0]      st_r, st_nxt;
  logic                     emp_r, emp_nxt;
  logic                     full_r, full_nxt;

  assign empty = !valid_w[0];
  assign full  = valid_w[DEPTH-1];

  assign in_w.ready = !out_valid_r || out_w.ready;
  assign fire       = in_w.valid && in_w.ready;
  assign cell_ctrl  = fire ? ctrl : '0;

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      logic signed [DATA_W-1:0] l_data, r_data;
      logic                     l_valid, r_valid;
      if (gi == 0) begin : g_head
        // A front push feeds the new word in at the head of the row.
        assign l_data  = in_w.push_value;
        assign l_valid = 1'b1;
      end else begin : g_mid
        assign l_data  = data_w[gi-1];
        assign l_valid = valid_w[gi-1];
      end
      if (gi == DEPTH-1) begin : g_tail
        assign r_data  = '0;
        assign r_valid = 1'b0;
      end else begin : g_body
        assign r_data  = data_w[gi+1];
        assign r_valid = valid_w[gi+1];
      end
      cd_cell u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (cell_ctrl),
        .push_value  (in_w.push_value),
        .left_data   (l_data),
        .left_valid  (l_valid),
        .right_data  (r_data),
        .right_valid (r_valid),
        .data_o      (data_w[gi]),
        .valid_o     (valid_w[gi]),
        .tap_o       (tap_w[gi])
      );
    end
  endgenerate

  // At most one cell, the rear one, drives its word onto its tap; all others give zero.
  always_comb begin
    rear_data = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_data = rear_data | tap_w[i];
    end
  end

  // Request decode. Errors and unused codes leave the row untouched and
  // report the flags of the unchanged deque.
  always_comb begin
    ctrl     = '0;
    rd_nxt   = '0;
    st_nxt   = ST_OK;
    emp_nxt  = empty;
    full_nxt = full;
    case (in_w.op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (full) begin
          st_nxt = ST_OVERFLOW;
        end else begin
          ctrl.push_front = (in_w.op == OP_PUSH_FRONT);
          ctrl.push_rear  = (in_w.op == OP_PUSH_REAR);
          emp_nxt         = 1'b0;
          full_nxt        = valid_w[DEPTH-2];
        end
      end
      OP_POP_FRONT, OP_POP_REAR: begin
        if (empty) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          ctrl.pop_front = (in_w.op == OP_POP_FRONT);
          ctrl.pop_rear  = (in_w.op == OP_POP_REAR);
          rd_nxt         = (in_w.op == OP_POP_FRONT) ? data_w[0] : rear_data;
          emp_nxt        = !valid_w[1];
          full_nxt       = 1'b0;
        end
      end
      OP_PEEK_FRONT: begin
        if (empty) begin
          st_nxt = ST_UNDERFLOW;
        end else begin
          rd_nxt = data_w[0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_w.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rd_r   <= rd_nxt;
      st_r   <= st_nxt;
      emp_r  <= emp_nxt;
      full_r <= full_nxt;
    end
  end

  assign out_w.valid      = out_valid_r;
  assign out_w.read_value = rd_r;
  assign out_w.status     = st_r;
  assign out_w.is_empty   = emp_r;
  assign out_w.is_full    = full_r;

  `include "circular_deque_assert.svh"

  `CD_ASSERT(a_compact, (valid_w & (valid_w + {{(DEPTH-1){1'b0}}, 1'b1})) == '0, "cells not compacted")
  `CD_ASSERT(a_ovf_full, out_valid_r && st_r == ST_OVERFLOW |-> full_r && rd_r == '0, "overflow while not full")
  `CD_ASSERT(a_udf_empty, out_valid_r && st_r == ST_UNDERFLOW |-> emp_r && rd_r == '0, "underflow while not empty")
  `CD_ASSERT(a_flags, out_valid_r |-> !(emp_r && full_r), "empty and full together")
  `CD_ASSERT(a_push_lands, fire && !full && (in_w.op == OP_PUSH_FRONT || in_w.op == OP_PUSH_REAR) |=> valid_w[0], "push lost")

endmodule

// ----- rtl/cd_cell.sv -----
// One storage cell of the deque row; entries sit front first from cell 0.
module cd_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  cd_pkg::cd_ctrl_t                 ctrl,
  input  logic signed [cd_pkg::DATA_W-1:0] push_value,
  input  logic signed [cd_pkg::DATA_W-1:0] left_data,
  input  logic                             left_valid,
  input  logic signed [cd_pkg::DATA_W-1:0] right_data,
  input  logic                             right_valid,
  output logic signed [cd_pkg::DATA_W-1:0] data_o,
  output logic                             valid_o,
  output logic signed [cd_pkg::DATA_W-1:0] tap_o
);
  import cd_pkg::*;

  logic signed [DATA_W-1:0] data_r, data_nxt;
  logic                     valid_r, valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    if (ctrl.push_front) begin
      data_nxt  = left_data;
      valid_nxt = left_valid;
    end else if (ctrl.push_rear) begin
      // The first free cell, behind an occupied one or cell 0 of an empty row, takes the new rear word.
      if (!valid_r && left_valid) begin
        data_nxt  = push_value;
        valid_nxt = 1'b1;
      end
    end else if (ctrl.pop_front) begin
      data_nxt  = right_data;
      valid_nxt = right_valid;
    end else if (ctrl.pop_rear) begin
      if (valid_r && !right_valid) begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;
  // Only the rear cell drives its word onto the rear read tap.
  assign tap_o   = (valid_r && !right_valid) ? data_r : '0;

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for the circular deque: random and directed request words, checked in order.
module testbench;
  import cd_pkg::*;

  localparam int DEQ_DEPTH      = DEPTH_DEF;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 4;

  // Op codes the block decodes as no-ops; the package names only the used ones.
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_C = 3'd7;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic signed [DATA_W-1:0] push_value;
  } deque_request_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [STATUS_W-1:0]      status;
    logic                     is_empty;
    logic                     is_full;
  } deque_result_t;

  logic clk;
  logic rst_n;

  cd_in_if  req_w ();
  cd_out_if rsp_w ();

  circular_deque #(.DEPTH(DEQ_DEPTH)) i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_w  (req_w),
    .out_w (rsp_w)
  );

  // Request words waiting to be sent, and result words the block still owes us.
  deque_request_t request_words[$];
  deque_result_t  owed_results[$];

  // Shadow copy of the deque contents and indices.
  logic signed [DATA_W-1:0] shadow_ring [DEQ_DEPTH];
  int shadow_head  = 0;
  int shadow_tail  = 0;
  bit shadow_empty = 1'b1;

  int  send_idle_pct = 33;
  int  recv_idle_pct = 33;
  bit  hold_request  = 1'b0;
  int  hold_left     = 0;
  bit  word_taken    = 1'b0;
  int  cycle_count   = 0;
  int  mismatch_count = 0;
  int  results_seen  = 0;
  int  ok_count      = 0;
  int  overflow_count  = 0;
  int  underflow_count = 0;
  int  full_count    = 0;
  int  spare_count   = 0;

  function automatic int ring_next(int i);
    return (i == DEQ_DEPTH - 1) ? 0 : i + 1;
  endfunction

  function automatic int ring_prev(int i);
    return (i == 0) ? DEQ_DEPTH - 1 : i - 1;
  endfunction

  function automatic bit shadow_full();
    return !shadow_empty && (shadow_head == ring_next(shadow_tail));
  endfunction

  // Applies one request to the shadow deque and returns the result word it owes.
  function automatic deque_result_t apply_deque_request(logic [OP_W-1:0] op,
                                                        logic signed [DATA_W-1:0] value);
    deque_result_t res;
    res.read_value = '0;
    res.status     = ST_OK;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (shadow_full()) begin
          res.status = ST_OVERFLOW;
        end else if (shadow_empty) begin
          // The first entry always lands in slot zero.
          shadow_head    = 0;
          shadow_tail    = 0;
          shadow_empty   = 1'b0;
          shadow_ring[0] = value;
        end else if (op == OP_PUSH_FRONT) begin
          shadow_head = ring_prev(shadow_head);
          shadow_ring[shadow_head] = value;
        end else begin
          shadow_tail = ring_next(shadow_tail);
          shadow_ring[shadow_tail] = value;
        end
      end
      OP_POP_FRONT, OP_POP_REAR, OP_PEEK_FRONT: begin
        if (shadow_empty) begin
          res.status = ST_UNDERFLOW;
        end else if (op == OP_PEEK_FRONT) begin
          res.read_value = shadow_ring[shadow_head];
        end else begin
          res.read_value = (op == OP_POP_FRONT) ? shadow_ring[shadow_head]
                                                : shadow_ring[shadow_tail];
          if (shadow_head == shadow_tail) begin
            // Last entry gone: both indices go home.
            shadow_empty = 1'b1;
            shadow_head  = 0;
            shadow_tail  = 0;
          end else if (op == OP_POP_FRONT) begin
            shadow_head = ring_next(shadow_head);
          end else begin
            shadow_tail = ring_prev(shadow_tail);
          end
        end
      end
      default: begin
      end
    endcase
    res.is_empty = shadow_empty;
    res.is_full  = shadow_full();
    return res;
  endfunction

  task automatic queue_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
    deque_request_t req;
    req.op         = op;
    req.push_value = value;
    request_words.push_back(req);
  endtask

  // Random requests in short runs that lean either toward pushing or toward
  // popping, so the deque keeps swinging between empty and full.
  task automatic queue_random_requests(int count);
    int push_pct;
    int pick;
    for (int n = 0; n < count; n++) begin
      if (n % 16 == 0) push_pct = ($urandom_range(1) != 0) ? 70 : 30;
      pick = $urandom_range(99);
      if (pick < push_pct) begin
        queue_request(($urandom_range(1) != 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, $urandom);
      end else if (pick < 94) begin
        case ($urandom_range(3))
          0:       queue_request(OP_PEEK_FRONT, $urandom);
          1:       queue_request(OP_POP_REAR, $urandom);
          default: queue_request(OP_POP_FRONT, $urandom);
        endcase
      end else begin
        case ($urandom_range(2))
          0:       queue_request(OP_SPARE_A, $urandom);
          1:       queue_request(OP_SPARE_B, $urandom);
          default: queue_request(OP_SPARE_C, $urandom);
        endcase
      end
    end
  endtask

  task automatic wait_all_sent();
    while (request_words.size() != 0 || req_w.valid) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n            = 1'b0;
    req_w.valid      = 1'b0;
    req_w.op         = OP_PUSH_FRONT;
    req_w.push_value = '0;
    rsp_w.ready      = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: errors on an empty deque, extreme values, filling to
    // full, overflow at both ends, draining the last entry, and wrapping the
    // head backwards past slot zero.
    queue_request(OP_POP_FRONT, 32'sd0);
    queue_request(OP_POP_REAR, 32'sd0);
    queue_request(OP_PEEK_FRONT, 32'sd0);
    queue_request(OP_SPARE_A, -32'sd1);
    queue_request(OP_PUSH_REAR, 32'sh7fffffff);
    queue_request(OP_PEEK_FRONT, 32'sd0);
    queue_request(OP_PUSH_FRONT, 32'sh80000000);
    queue_request(OP_PUSH_REAR, -32'sd1);
    queue_request(OP_PUSH_FRONT, 32'sd0);
    queue_request(OP_PUSH_FRONT, 32'sd1234);
    queue_request(OP_PUSH_REAR, 32'sh55555555);
    queue_request(OP_SPARE_B, 32'sh55555555);
    queue_request(OP_PEEK_FRONT, 32'sd0);
    queue_request(OP_POP_REAR, 32'sd0);
    queue_request(OP_POP_FRONT, 32'sd0);
    queue_request(OP_PUSH_REAR, 32'shaaaaaaaa);
    queue_request(OP_POP_FRONT, 32'sd0);
    queue_request(OP_POP_REAR, 32'sd0);
    queue_request(OP_POP_FRONT, 32'sd0);
    queue_request(OP_SPARE_C, 32'shaaaaaaaa);
    queue_request(OP_PUSH_FRONT, 32'sh0f0f0f0f);
    queue_request(OP_POP_REAR, 32'sd0);
    queue_request(OP_PUSH_FRONT, 32'sh12345678);
    queue_request(OP_PUSH_FRONT, -32'sd2);
    queue_request(OP_POP_FRONT, 32'sd0);
    wait_all_sent();

    // Random traffic with idling on both sides, and a long receiver stall
    // while the sender still has plenty queued.
    queue_random_requests(700);
    while (request_words.size() > 400) @(posedge clk);
    hold_request = 1'b1;
    wait_all_sent();

    // A stretch at full rate with neither side idling.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random_requests(400);
    wait_all_sent();

    send_idle_pct = 33;
    recv_idle_pct = 33;
    queue_random_requests(625);
    while (request_words.size() > 300) @(posedge clk);
    hold_request = 1'b1;
    wait_all_sent();

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d result words: %0d ok, %0d overflow, %0d underflow, %0d spare op codes.",
             results_seen, ok_count, overflow_count, underflow_count, spare_count);
    $display("The deque reported full %0d times; %0d field mismatches.",
             full_count, mismatch_count);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Sender: a new word goes out only after the previous one was taken.
  always @(negedge clk) begin : request_driver
    deque_request_t next_req;
    if (!rst_n) begin
      req_w.valid <= 1'b0;
    end else if (!req_w.valid || word_taken) begin
      if (request_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_req = request_words.pop_front();
        req_w.valid      <= 1'b1;
        req_w.op         <= next_req.op;
        req_w.push_value <= next_req.push_value;
      end else begin
        req_w.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off on request.
  always @(negedge clk) begin
    if (!rst_n) begin
      rsp_w.ready <= 1'b0;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
      rsp_w.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    = hold_left - 1;
      rsp_w.ready <= 1'b0;
    end else begin
      rsp_w.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Monitor: predicts on every accepted request and checks every accepted result.
  always @(posedge clk) begin : result_monitor
    deque_result_t want;
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= req_w.valid && req_w.ready;
      if (req_w.valid && req_w.ready) begin
        owed_results.push_back(apply_deque_request(req_w.op, req_w.push_value));
        if (req_w.op > OP_PEEK_FRONT) spare_count++;
      end
      if (rsp_w.valid && rsp_w.ready) begin
        results_seen++;
        if (owed_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: result word with none expected: value %0d status %0d",
                   $time, rsp_w.read_value, rsp_w.status);
        end else begin
          want = owed_results.pop_front();
          case (want.status)
            ST_OVERFLOW:  overflow_count++;
            ST_UNDERFLOW: underflow_count++;
            default:      ok_count++;
          endcase
          if (want.is_full) full_count++;
          if (rsp_w.read_value !== want.read_value) begin
            mismatch_count++;
            $display("%0t: read_value expected %0d actual %0d",
                     $time, want.read_value, rsp_w.read_value);
          end
          if (rsp_w.status !== want.status) begin
            mismatch_count++;
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_w.status);
          end
          if (rsp_w.is_empty !== want.is_empty) begin
            mismatch_count++;
            $display("%0t: is_empty expected %0b actual %0b",
                     $time, want.is_empty, rsp_w.is_empty);
          end
          if (rsp_w.is_full !== want.is_full) begin
            mismatch_count++;
            $display("%0t: is_full expected %0b actual %0b",
                     $time, want.is_full, rsp_w.is_full);
          end
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d requests and %0d results pending.",
               cycle_count, request_words.size(), owed_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

endmodule
